// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- src/psev_pkg.sv -----
// ----------------------------------------------------------------------------
// psev_pkg
// Shared types and codes of the prefix expression evaluator.
// ----------------------------------------------------------------------------
package psev_pkg;

  localparam int VAL_W = 32;

  localparam logic [1:0] OP_SUB = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;

  localparam logic [1:0] ERR_OK  = 2'd0;
  localparam logic [1:0] ERR_OVF = 2'd1;
  localparam logic [1:0] ERR_INC = 2'd2;

  typedef struct packed {
    logic             is_num;
    logic [VAL_W-1:0] val;
  } entry_t;

endpackage

// ----- src/psev_stack_mem.sv -----
// ----------------------------------------------------------------------------
// psev_stack_mem
// Stack storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module psev_stack_mem #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  psev_pkg::entry_t wr_data,
  input  logic [AW-1:0]    rd_addr_a,
  input  logic [AW-1:0]    rd_addr_b,
  output psev_pkg::entry_t rd_data_a,
  output psev_pkg::entry_t rd_data_b
);

  psev_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

// ----- src/psev_alu.sv -----
// ----------------------------------------------------------------------------
// psev_alu
// Applies a stacked operator entry to two operand values, wrapping.
// ----------------------------------------------------------------------------
module psev_alu (
  input  psev_pkg::entry_t                op,
  input  logic [psev_pkg::VAL_W-1:0]      lhs,
  input  logic [psev_pkg::VAL_W-1:0]      rhs,
  output logic [psev_pkg::VAL_W-1:0]      res
);

  always_comb begin
    res = '0;
    if (!op.is_num) begin
      case (op.val[1:0])
        psev_pkg::OP_SUB: res = lhs - rhs;
        psev_pkg::OP_ADD: res = lhs + rhs;
        psev_pkg::OP_MUL: res = lhs * rhs;
        default:          res = '0;
      endcase
    end
  end

endmodule

// ----- src/prefix_expression_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// prefix_expression_evaluator_core
// Prefix notation evaluator on a tagged stack held in a two-read-port memory.
// ----------------------------------------------------------------------------
// channel | dir | fields                                            | handshake
// in_     | in  | is_operand, operator_code, operand_value, last_token | valid/ready
// out_    | out | expression_value, error_code                       | valid/ready
//
// A word is pushed in S_IDLE, and each reduction it triggers then runs in S_RED.
// Reductions chain one per cycle: the operator and the next-below entry are
// read ahead of use from the registered stack memory ports; the top two are kept in regs.
// A last word then passes through S_FIN to post the result into the output register,
// and stalls there while a previous result is still waiting.
// Reset is synchronous; the stack memory needs no clearing.
// ----------------------------------------------------------------------------
module prefix_expression_evaluator_core #(
  parameter int STACK_DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_is_operand,
  input  logic [1:0]         in_operator_code,
  input  logic signed [31:0] in_operand_value,
  input  logic               in_last_token,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_expression_value,
  output logic [1:0]         out_error_code
);

  `include "assert_macros.svh"

  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW = $clog2(STACK_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RED  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             last_r, last_nxt;
  psev_pkg::entry_t top_r, top_nxt;
  psev_pkg::entry_t sec_r, sec_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_val_r, out_val_nxt;
  logic [1:0]       out_err_r, out_err_nxt;

  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  psev_pkg::entry_t wr_data;
  logic [AW-1:0]    rd_addr_a;
  logic [AW-1:0]    rd_addr_b;
  psev_pkg::entry_t rd_a;
  psev_pkg::entry_t rd_b;

  psev_pkg::entry_t new_ent;
  logic [31:0]      alu_res;
  logic             fin_load;

  psev_stack_mem #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  psev_alu u_alu (
    .op  (rd_a),
    .lhs (sec_r.val),
    .rhs (top_r.val),
    .res (alu_res)
  );

  assign in_ready             = (state_r == S_IDLE);
  assign out_valid            = out_valid_r;
  assign out_expression_value = $signed(out_val_r);
  assign out_error_code       = out_err_r;

  always_comb begin
    new_ent.is_num = in_is_operand;
    new_ent.val    = in_is_operand ? $unsigned(in_operand_value) : 32'(in_operator_code);
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    top_nxt       = top_r;
    sec_nxt       = sec_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_val_nxt   = out_val_r;
    out_err_nxt   = out_err_r;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[AW-1:0];
    wr_data       = new_ent;
    rd_addr_a     = '0;
    rd_addr_b     = '0;
    fin_load      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt = in_last_token;
          if (32'(cnt_r) < STACK_DEPTH) begin
            wr_en   = 1'b1;
            top_nxt = new_ent;
            sec_nxt = top_r;
            cnt_nxt = cnt_r + CW'(1);
            if ((32'(cnt_r) >= 32'd2) && new_ent.is_num && top_r.is_num) begin
              rd_addr_a = AW'(32'(cnt_r) - 32'd2);
              if (32'(cnt_r) >= 32'd3) begin
                rd_addr_b = AW'(32'(cnt_r) - 32'd3);
              end
              state_nxt = S_RED;
            end else if (in_last_token) begin
              state_nxt = S_FIN;
            end
          end else begin
            ovf_nxt = 1'b1;
            if (in_last_token) begin
              state_nxt = S_FIN;
            end
          end
        end
      end

      S_RED: begin
        wr_en          = 1'b1;
        wr_addr        = AW'(32'(cnt_r) - 32'd3);
        wr_data.is_num = 1'b1;
        wr_data.val    = alu_res;
        top_nxt        = wr_data;
        sec_nxt        = rd_b;
        cnt_nxt        = cnt_r - CW'(2);
        if ((32'(cnt_r) >= 32'd5) && rd_b.is_num) begin
          rd_addr_a = AW'(32'(cnt_r) - 32'd5);
          if (32'(cnt_r) >= 32'd6) begin
            rd_addr_b = AW'(32'(cnt_r) - 32'd6);
          end
        end else begin
          state_nxt = last_r ? S_FIN : S_IDLE;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          fin_load      = 1'b1;
          out_valid_nxt = 1'b1;
          out_val_nxt   = '0;
          if (ovf_r) begin
            out_err_nxt = psev_pkg::ERR_OVF;
          end else if ((32'(cnt_r) != 32'd1) || !top_r.is_num) begin
            out_err_nxt = psev_pkg::ERR_INC;
          end else begin
            out_err_nxt = psev_pkg::ERR_OK;
            out_val_nxt = top_r.val;
          end
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    top_r     <= top_nxt;
    sec_r     <= sec_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, 32'(cnt_r) <= STACK_DEPTH)
  `ASSERT_IMPL(a_red_depth, clk, rst_n, state_r == S_RED, 32'(cnt_r) >= 32'd3)
  `ASSERT_IMPL(a_err_zero, clk, rst_n, out_valid_r && (out_err_r != psev_pkg::ERR_OK), out_val_r == 32'd0)
  `ASSERT_NEXT(a_fin_clear, clk, rst_n, fin_load, (cnt_r == '0) && !ovf_r && out_valid_r)

endmodule

// ----- sim/tb_prefix_expression_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// tb_prefix_expression_evaluator_core
// Self-checking bench for the prefix expression evaluator. A directed table
// covers value extremes, every operator, the unused operator code, operand in
// the operator slot and incomplete expressions. Random prefix expressions
// follow: mostly well formed, some broken, some that overflow the stack. Both
// channels idle and stall at random. Directed result words are checked against
// the table, random ones against a behavioral stack evaluator running alongside.
// ----------------------------------------------------------------------------
module tb_prefix_expression_evaluator_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         STACK_DEPTH  = 32;
  localparam int         RANDOM_WORDS = 700;
  localparam logic [1:0] OP_UNUSED    = 2'd3;

  typedef struct packed {
    logic        is_num;
    logic [1:0]  op;
    logic [31:0] value;
    logic        last;
  } token_t;

  typedef struct packed {
    token_t      tok;
    logic        chk;
    logic [31:0] exp_value;
    logic [1:0]  exp_err;
  } dir_row_t;

  typedef struct packed {
    logic [31:0] value;
    logic [1:0]  err;
  } result_t;

  logic               clk                  = 1'b0;
  logic               rst_n                = 1'b0;
  logic               in_valid             = 1'b0;
  logic               in_ready;
  logic               in_is_operand        = 1'b0;
  logic [1:0]         in_operator_code     = psev_pkg::OP_SUB;
  logic signed [31:0] in_operand_value     = '0;
  logic               in_last_token        = 1'b0;
  logic               out_valid;
  logic               out_ready            = 1'b0;
  logic signed [31:0] out_expression_value;
  logic [1:0]         out_error_code;

  psev_pkg::entry_t token_stack [STACK_DEPTH];
  int unsigned      token_depth;
  bit               token_overflow;
  result_t          pending_results [$];
  token_t           expr_q [$];
  int               fail_count;
  int               random_words;
  bit               burst;

  dir_row_t dir_table [0:25] = '{
    '{'{1'b1, psev_pkg::OP_SUB, 32'd7,        1'b1}, 1'b1, 32'd7,        psev_pkg::ERR_OK},
    '{'{1'b0, psev_pkg::OP_ADD, 32'd0,        1'b1}, 1'b1, 32'd0,        psev_pkg::ERR_INC},
    '{'{1'b1, psev_pkg::OP_MUL, 32'h7fffffff, 1'b1}, 1'b1, 32'h7fffffff, psev_pkg::ERR_OK},
    '{'{1'b1, OP_UNUSED,        32'h80000000, 1'b1}, 1'b1, 32'h80000000, psev_pkg::ERR_OK},
    '{'{1'b0, psev_pkg::OP_ADD, 32'hffffffff, 1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'h7fffffff, 1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'd1,        1'b1}, 1'b1, 32'h80000000, psev_pkg::ERR_OK},
    '{'{1'b0, psev_pkg::OP_SUB, 32'h5a5a5a5a, 1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_ADD, 32'h80000000, 1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_ADD, 32'd1,        1'b1}, 1'b1, 32'h7fffffff, psev_pkg::ERR_OK},
    '{'{1'b0, psev_pkg::OP_MUL, 32'ha5a5a5a5, 1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'h00010000, 1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'h00010000, 1'b1}, 1'b1, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b0, OP_UNUSED,        32'd0,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'd5,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'd6,        1'b1}, 1'b1, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_ADD, 32'd1,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_ADD, 32'd2,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_ADD, 32'd3,        1'b1}, 1'b1, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b0, psev_pkg::OP_SUB, 32'd0,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'd9,        1'b1}, 1'b1, 32'd0,        psev_pkg::ERR_INC},
    '{'{1'b0, psev_pkg::OP_MUL, 32'd0,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b0, psev_pkg::OP_ADD, 32'd0,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'd2,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'd3,        1'b0}, 1'b0, 32'd0,        psev_pkg::ERR_OK},
    '{'{1'b1, psev_pkg::OP_SUB, 32'hfffffffc, 1'b1}, 1'b1, 32'hffffffec, psev_pkg::ERR_OK}
  };

  prefix_expression_evaluator_core #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_is_operand       (in_is_operand),
    .in_operator_code    (in_operator_code),
    .in_operand_value    (in_operand_value),
    .in_last_token       (in_last_token),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_expression_value(out_expression_value),
    .out_error_code      (out_error_code)
  );

  always #10 clk = ~clk;

  // ---- stack evaluator ----
  function automatic logic [31:0] combine(psev_pkg::entry_t opr, logic [31:0] lhs,
                                          logic [31:0] rhs);
    logic [31:0] r;
    r = '0;
    if (!opr.is_num) begin
      case (opr.val[1:0])
        psev_pkg::OP_SUB: r = lhs - rhs;
        psev_pkg::OP_ADD: r = lhs + rhs;
        psev_pkg::OP_MUL: r = lhs * rhs;
        default:          r = '0;
      endcase
    end
    return r;
  endfunction

  function automatic bit evaluate_token(token_t t, output result_t res);
    logic [31:0] folded;
    res = '0;
    if (token_depth < STACK_DEPTH) begin
      token_stack[token_depth].is_num = t.is_num;
      token_stack[token_depth].val    = t.is_num ? t.value : {30'd0, t.op};
      token_depth++;
      while (token_depth > 2 && token_stack[token_depth-1].is_num &&
             token_stack[token_depth-2].is_num) begin
        folded = combine(token_stack[token_depth-3], token_stack[token_depth-2].val,
                         token_stack[token_depth-1].val);
        token_depth -= 2;
        token_stack[token_depth-1].is_num = 1'b1;
        token_stack[token_depth-1].val    = folded;
      end
    end else begin
      token_overflow = 1'b1;
    end
    if (!t.last) return 1'b0;
    if (token_overflow) res.err = psev_pkg::ERR_OVF;
    else if (token_depth != 1 || !token_stack[0].is_num) res.err = psev_pkg::ERR_INC;
    else begin
      res.err   = psev_pkg::ERR_OK;
      res.value = token_stack[0].val;
    end
    token_depth    = 0;
    token_overflow = 1'b0;
    return 1'b1;
  endfunction

  // ---- random tokens ----
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0:       v = 32'h7fffffff;
      1:       v = 32'h80000000;
      2:       v = $urandom_range(0, 9);
      3:       v = -$urandom_range(1, 9);
      default: v = $urandom();
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_op();
    logic [1:0] c;
    if ($urandom_range(0, 99) < 4) c = OP_UNUSED;
    else begin
      case ($urandom_range(0, 2))
        0:       c = psev_pkg::OP_SUB;
        1:       c = psev_pkg::OP_ADD;
        default: c = psev_pkg::OP_MUL;
      endcase
    end
    return c;
  endfunction

  function automatic token_t num_tok();
    token_t t;
    t.is_num = 1'b1;
    t.op     = 2'($urandom_range(0, 3));
    t.value  = pick_value();
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic token_t op_tok();
    token_t t;
    t.is_num = 1'b0;
    t.op     = pick_op();
    t.value  = $urandom();
    t.last   = 1'b0;
    return t;
  endfunction

  function automatic token_t any_tok();
    return ($urandom_range(0, 1) == 1) ? num_tok() : op_tok();
  endfunction

  function automatic void append_tok(token_t t);
    expr_q.insert(expr_q.size(), t);
  endfunction

  function automatic void build_expr(int depth);
    if (depth == 0 || $urandom_range(0, 3) == 0) append_tok(num_tok());
    else begin
      append_tok(op_tok());
      build_expr(depth - 1);
      build_expr(depth - 1);
    end
  endfunction

  function automatic void make_sequence();
    int     kind;
    int     n;
    token_t t;
    expr_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      build_expr($urandom_range(0, 5));
    end else if (kind < 80) begin
      build_expr($urandom_range(1, 4));
      if (expr_q.size() > 1 && $urandom_range(0, 1) == 1)
        expr_q.delete($urandom_range(0, expr_q.size() - 1));
      else
        expr_q.insert($urandom_range(0, expr_q.size()), any_tok());
    end else if (kind < 88) begin
      n = $urandom_range(1, 10);
      repeat (n) append_tok(any_tok());
    end else if (kind < 93) begin
      // operators pile up to around and past the stack limit
      n = $urandom_range(STACK_DEPTH - 3, STACK_DEPTH + 6);
      repeat (n) append_tok(op_tok());
      repeat ($urandom_range(1, 3)) append_tok(num_tok());
    end else begin
      // right-leaning chain around the stack limit
      n = $urandom_range(STACK_DEPTH / 2 - 3, STACK_DEPTH / 2 + 1);
      repeat (n) begin
        append_tok(op_tok());
        append_tok(num_tok());
      end
      append_tok(num_tok());
    end
    t = expr_q.pop_back();
    t.last = 1'b1;
    append_tok(t);
  endfunction

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // ---- input channel ----
  task automatic send_word(token_t t, int gap, logic chk, logic [31:0] exp_value,
                           logic [1:0] exp_err);
    result_t res;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_is_operand    <= t.is_num;
    in_operator_code <= t.op;
    in_operand_value <= t.value;
    in_last_token    <= t.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (evaluate_token(t, res)) begin
      if (chk) begin
        res.value = exp_value;
        res.err   = exp_err;
      end
      pending_results.insert(pending_results.size(), res);
    end
  endtask

  // ---- output channel ----
  initial begin
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(50, 200)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      out_ready <= 1'b0;
      if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 40)) @(posedge clk);
      else repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: value %0d, error_code %0d",
               out_expression_value, out_error_code);
        fail_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_expression_value !== exp_r.value) begin
          $error("expression_value: expected %0d, got %0d",
                 $signed(exp_r.value), out_expression_value);
          fail_count++;
        end
        if (out_error_code !== exp_r.err) begin
          $error("error_code: expected %0d, got %0d", exp_r.err, out_error_code);
          fail_count++;
        end
      end
    end
  end

  // ---- main sequence ----
  initial begin
    token_depth    = 0;
    token_overflow = 1'b0;
    fail_count     = 0;
    random_words   = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i])
      send_word(dir_table[i].tok, pick_gap(1'b0), dir_table[i].chk,
                dir_table[i].exp_value, dir_table[i].exp_err);

    while (random_words < RANDOM_WORDS) begin
      make_sequence();
      burst = ($urandom_range(0, 4) == 0);
      foreach (expr_q[i])
        send_word(expr_q[i], pick_gap(burst), 1'b0, '0, psev_pkg::ERR_OK);
      random_words += expr_q.size();
    end

    @(posedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
